[hw/rtl/sle_pkg.sv]
// Shared types and constants for the sequential list engine.
// No dependencies; used by sle_cell and sequential_list_engine_top.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned OP_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_READ   = 3'd2,
    OP_LOCATE = 3'd3,
    OP_DEL_EQ = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_DUMP   = 3'd6,
    OP_BAD    = 3'd7
  } op_t;

  // Per-cycle command broadcast to every cell of the ring.
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_ROT,
    ACT_DROP,
    ACT_APPEND
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/sle_cell.sv]
// One storage cell of the list ring: holds one element.
// Depends on sle_pkg (act_t, DATA_W).
`timescale 1ns / 1ps
`default_nettype none

module sle_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned LW  = 6
) (
  input  wire logic                         clk,
  input  wire sle_pkg::act_t                act,
  input  wire logic [LW-1:0]                len,
  input  wire logic [sle_pkg::DATA_W-1:0]   head,
  input  wire logic [sle_pkg::DATA_W-1:0]   right,
  input  wire logic [sle_pkg::DATA_W-1:0]   ins_value,
  output logic      [sle_pkg::DATA_W-1:0]   data
);

  logic below_tail;
  logic at_tail;
  logic at_free;

  assign below_tail = LW'(IDX + 1) < len;
  assign at_tail    = LW'(IDX + 1) == len;
  assign at_free    = LW'(IDX) == len;

  always_ff @(posedge clk) begin
    case (act)
      sle_pkg::ACT_ROT: begin
        if (below_tail) begin
          data <= right;
        end else if (at_tail) begin
          data <= head;
        end
      end
      sle_pkg::ACT_DROP: begin
        if (below_tail) begin
          data <= right;
        end
      end
      sle_pkg::ACT_APPEND: begin
        if (at_free) begin
          data <= ins_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/sequential_list_engine_top.sv]
// Top level of the sequential list engine: request sequencer and ring of cells.
// Depends on sle_pkg and sle_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A request (op, position, value) is taken at a rising edge with start high
// and busy low. busy stays high until the request has finished.
// Results appear on status, value_out, found_position, count and last for
// one cycle each, marked by strobe; last is set on the final one. The
// receiver takes every result as it comes and cannot stall the block.
// Storage is a ring of CAPACITY cells; the element at the head cell is the
// only one inspected. Every pass turns the live part of the ring one place a
// cycle, dropping or appending an element on the way, so order is restored
// once all n elements have gone past the head.
// Errors and clear give their result without turning the ring; locate,
// read, delete, delete-equal and insert give theirs after the ring has
// turned past all n elements, where n is the list length; dump gives one
// result per cycle as it turns. busy is already low while the last strobe
// is high, so the next request can be taken at the edge that ends that
// cycle. Reset empties the list; element contents are left as they are.
module sequential_list_engine_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [sle_pkg::OP_W-1:0]           op,
  input  wire logic [sle_pkg::POS_W-1:0]          position,
  input  wire logic signed [sle_pkg::DATA_W-1:0]  value,
  output logic                                    strobe,
  output logic                                    status,
  output logic signed [sle_pkg::DATA_W-1:0]       value_out,
  output logic [sle_pkg::POS_W-1:0]               found_position,
  output logic [sle_pkg::POS_W-1:0]               count,
  output logic                                    last
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > sle_pkg::POS_W) ? LW : sle_pkg::POS_W) + 1;

  sle_pkg::state_t state, state_next;
  sle_pkg::op_t    op_q;
  sle_pkg::act_t   act;

  logic [sle_pkg::POS_W-1:0]  pos_q;
  logic [sle_pkg::DATA_W-1:0] val_q;
  logic                       err_q;
  logic                       err_in;
  logic [LW-1:0]              len, len_next;
  logic [LW-1:0]              n;
  logic [LW-1:0]              k, k_next;
  logic [LW-1:0]              found, found_next;
  logic [sle_pkg::DATA_W-1:0] rd, rd_next;
  logic [LW-1:0]              n_steps;
  logic                       head_hit;

  logic                       res_v;
  logic                       res_status;
  logic [sle_pkg::DATA_W-1:0] res_value;
  logic [LW-1:0]              res_found;
  logic                       res_last;

  logic [sle_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [sle_pkg::DATA_W-1:0] head;

  assign head = cell_data[0];
  assign busy = (state == sle_pkg::ST_RUN);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [sle_pkg::DATA_W-1:0] right;
    if (i == CAPACITY - 1) begin : g_end
      assign right = head;
    end else begin : g_mid
      assign right = cell_data[i + 1];
    end
    sle_cell #(
      .IDX(i),
      .LW (LW)
    ) u_cell (
      .clk      (clk),
      .act      (act),
      .len      (len),
      .head     (head),
      .right    (right),
      .ins_value(val_q),
      .data     (cell_data[i])
    );
  end

  // Request check at acceptance
  always_comb begin
    case (sle_pkg::op_t'(op))
      sle_pkg::OP_INSERT:
        err_in = (len >= LW'(CAPACITY)) || (position == '0) ||
                 (CW'(position) > CW'(len) + CW'(1));
      sle_pkg::OP_DELETE, sle_pkg::OP_READ:
        err_in = (position == '0) || (CW'(position) > CW'(len));
      sle_pkg::OP_DEL_EQ:
        err_in = (len == '0);
      sle_pkg::OP_BAD:
        err_in = 1'b1;
      default:
        err_in = 1'b0;
    endcase
  end

  assign n_steps  = n + LW'(op_q == sle_pkg::OP_INSERT);
  assign head_hit = (CW'(k) + CW'(1)) == CW'(pos_q);

  always_comb begin
    state_next = state;
    act        = sle_pkg::ACT_HOLD;
    len_next   = len;
    k_next     = k;
    found_next = found;
    rd_next    = rd;
    res_v      = 1'b0;
    res_status = 1'b0;
    res_value  = '0;
    res_found  = '0;
    res_last   = 1'b1;
    case (state)
      sle_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sle_pkg::ST_RUN;
        end
      end
      sle_pkg::ST_RUN: begin
        if (err_q) begin
          res_v      = 1'b1;
          res_status = 1'b1;
          state_next = sle_pkg::ST_IDLE;
        end else if (op_q == sle_pkg::OP_CLEAR) begin
          len_next   = '0;
          res_v      = 1'b1;
          state_next = sle_pkg::ST_IDLE;
        end else if (k == n_steps) begin
          res_v      = 1'b1;
          state_next = sle_pkg::ST_IDLE;
          if (op_q == sle_pkg::OP_READ) begin
            res_value = rd;
          end
          if (op_q == sle_pkg::OP_LOCATE) begin
            res_found = found;
          end
        end else begin
          k_next = k + LW'(1);
          case (op_q)
            sle_pkg::OP_INSERT: begin
              if (head_hit) begin
                act      = sle_pkg::ACT_APPEND;
                len_next = len + LW'(1);
              end else begin
                act = sle_pkg::ACT_ROT;
              end
            end
            sle_pkg::OP_DELETE: begin
              if (head_hit) begin
                act      = sle_pkg::ACT_DROP;
                len_next = len - LW'(1);
              end else begin
                act = sle_pkg::ACT_ROT;
              end
            end
            sle_pkg::OP_READ: begin
              act = sle_pkg::ACT_ROT;
              if (head_hit) begin
                rd_next = head;
              end
            end
            sle_pkg::OP_LOCATE: begin
              act = sle_pkg::ACT_ROT;
              if ((found == '0) && (head == val_q)) begin
                found_next = k + LW'(1);
              end
            end
            sle_pkg::OP_DEL_EQ: begin
              if (head == val_q) begin
                act      = sle_pkg::ACT_DROP;
                len_next = len - LW'(1);
              end else begin
                act = sle_pkg::ACT_ROT;
              end
            end
            sle_pkg::OP_DUMP: begin
              act       = sle_pkg::ACT_ROT;
              res_v     = 1'b1;
              res_value = head;
              res_last  = (k + LW'(1)) == n;
              if (res_last) begin
                state_next = sle_pkg::ST_IDLE;
              end
            end
            default: begin
              res_v      = 1'b1;
              res_status = 1'b1;
              state_next = sle_pkg::ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = sle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sle_pkg::ST_IDLE;
      len    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      len    <= len_next;
      strobe <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == sle_pkg::ST_IDLE) && start) begin
      op_q  <= sle_pkg::op_t'(op);
      pos_q <= position;
      val_q <= value;
      err_q <= err_in;
      n     <= len;
      k     <= '0;
      found <= '0;
      rd    <= '0;
    end else begin
      k     <= k_next;
      found <= found_next;
      rd    <= rd_next;
    end
    status         <= res_status;
    value_out      <= res_value;
    found_position <= sle_pkg::POS_W'(res_found);
    count          <= sle_pkg::POS_W'(len_next);
    last           <= res_last;
  end

`ifndef SYNTHESIS
  a_len_in_range: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(CAPACITY))
    else $error("list length above capacity");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final result while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_idle_len_stable: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(len))
    else $error("list length changed while idle");
`endif

endmodule

`default_nettype wire
